@@ hdl/apc_pkg.sv @@
`default_nettype none
package apc_pkg;

  localparam int unsigned NumJoints = 6;
  localparam int unsigned AngW      = 9;   // stored joint angle, degrees
  localparam int unsigned InAngW    = 10;  // requested joint angle, degrees
  localparam int unsigned ArgW      = 11;  // trig argument before mod 360
  localparam int unsigned TrigW     = 18;  // sine value, Q16 signed
  localparam int unsigned MulW      = 28;  // shared multiplier operand
  localparam int unsigned ProdW     = 2 * MulW;
  localparam int unsigned DivInW    = 43;  // signed mm Q32 value into the divider
  localparam int unsigned DivMagW   = 42;  // magnitude plus rounding bias
  localparam int unsigned RadW      = 16;
  localparam int unsigned PosW      = 16;
  localparam int unsigned JointIdxW = 3;

  // joint positions in the angle vector
  localparam int unsigned JointBase     = 0;
  localparam int unsigned JointShoulder = 1;
  localparam int unsigned JointElbow    = 2;

  typedef enum logic {
    OpSetOne = 1'b0,
    OpSetAll = 1'b1
  } opcode_e;

  typedef logic signed [AngW-1:0] angle_t;

  // link lengths in mm
  localparam int LinkUpper = 89;
  localparam int LinkFore  = 169;
  localparam int BaseReach = 173;
  localparam int BaseLift  = 196;

  localparam logic [16:0] SinTab [91] = '{
    17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
    17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
    17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
    17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
    17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
    17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
    17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
    17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
    17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
    17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
    17'd61584, 17'd61965, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
    17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
    17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
  };

  // limits are symmetric: -LimHi..LimHi inclusive
  localparam logic [7:0] LimHi [NumJoints] = '{
    8'd180, 8'd90, 8'd135, 8'd180, 8'd90, 8'd180
  };

  // sine of whole degrees in -360..719, Q16
  function automatic logic signed [TrigW-1:0] sine_deg(input logic signed [ArgW-1:0] d);
    logic signed [ArgW-1:0] a;
    logic [6:0]             idx;
    logic                   neg;
    logic signed [TrigW-1:0] val;
    a = d;
    if (a < 0) begin
      a = a + ArgW'(360);
    end else if (a >= ArgW'(360)) begin
      a = a - ArgW'(360);
    end
    if (a <= ArgW'(90)) begin
      idx = a[6:0];
      neg = 1'b0;
    end else if (a <= ArgW'(180)) begin
      idx = 7'(ArgW'(180) - a);
      neg = 1'b0;
    end else if (a <= ArgW'(270)) begin
      idx = 7'(a - ArgW'(180));
      neg = 1'b1;
    end else begin
      idx = 7'(ArgW'(360) - a);
      neg = 1'b1;
    end
    val = $signed({1'b0, SinTab[idx]});
    return neg ? -val : val;
  endfunction

  function automatic logic in_limits(input logic [JointIdxW-1:0] j,
                                     input logic signed [InAngW-1:0] a);
    logic signed [InAngW:0] hi;
    logic signed [InAngW:0] a_ext;
    if (j >= JointIdxW'(NumJoints)) begin
      return 1'b0;
    end
    hi    = $signed({3'b000, LimHi[j]});
    a_ext = (InAngW + 1)'(a);
    return (a_ext >= -hi) && (a_ext <= hi);
  endfunction

endpackage
`default_nettype wire

@@ hdl/apc_if.sv @@
`default_nettype none
interface apc_cmd_if;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [2:0]               joint_index;
  logic signed [9:0]        new_angle;
  logic signed [9:0]        base_angle;
  logic signed [9:0]        shoulder_angle;
  logic signed [9:0]        elbow_angle;
  logic signed [9:0]        roll_angle;
  logic signed [9:0]        pitch_angle;
  logic signed [9:0]        yaw_angle;

  modport source (
    output valid, opcode, joint_index, new_angle, base_angle, shoulder_angle,
           elbow_angle, roll_angle, pitch_angle, yaw_angle,
    input  ready
  );
  modport sink (
    input  valid, opcode, joint_index, new_angle, base_angle, shoulder_angle,
           elbow_angle, roll_angle, pitch_angle, yaw_angle,
    output ready
  );
endinterface

interface apc_res_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic               collision;
  logic               emergency_stop;

  modport source (
    output valid, accepted, pos_x, pos_y, pos_z, collision, emergency_stop,
    input  ready
  );
  modport sink (
    input  valid, accepted, pos_x, pos_y, pos_z, collision, emergency_stop,
    output ready
  );
endinterface
`default_nettype wire

@@ hdl/apc_mul.sv @@
`default_nettype none
// shared signed multiplier, product registered
module apc_mul (
  input  wire logic                                  clk_i,
  input  wire logic signed [apc_pkg::MulW-1:0]       a_i,
  input  wire logic signed [apc_pkg::MulW-1:0]       b_i,
  output logic signed [apc_pkg::ProdW-1:0]           prod_o
);

  logic signed [apc_pkg::ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= apc_pkg::ProdW'(a_i) * apc_pkg::ProdW'(b_i);
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

@@ hdl/apc_div.sv @@
`default_nettype none
// mm Q32 to metres Q(FracBits): divide by 1000 << (32-FracBits), rounding
// half away from zero. Drop the low Shift+3 bits, then divide by 125 with a
// reciprocal multiply; the reduced dividend and then the product are registered.
module apc_div #(
  parameter int unsigned FracBits = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic signed [apc_pkg::DivInW-1:0]  value_i,
  output logic                                    busy_o,
  output logic                                    done_o,
  output logic signed [FracBits+1:0]              quot_o
);

  localparam int unsigned Shift  = 32 - FracBits;
  localparam int unsigned QuotW  = apc_pkg::DivMagW - Shift - 9;
  // dividend after the shift stays below 2^31 while FracBits is at most 24
  localparam int unsigned RedW   = apc_pkg::DivMagW - 11;
  localparam int unsigned RecW   = 32;
  localparam int unsigned RecSh  = 38;
  localparam int unsigned RProdW = RedW + RecW;
  // ceil(2^38 / 125): exact floor division by 125 for dividends below 2^31
  localparam logic [RecW-1:0] Recip = 32'd2199023256;
  localparam logic [apc_pkg::DivMagW-1:0] Bias =
    apc_pkg::DivMagW'(500) + (apc_pkg::DivMagW'(1000) << (Shift - 1));

  logic [apc_pkg::DivInW-1:0]  mag;
  logic [apc_pkg::DivMagW-1:0] biased;
  logic [RedW-1:0]             red_q;
  logic [RProdW-1:0]           rprod_q;
  logic [QuotW-1:0]            quo;
  logic                        neg_q, red_vld_q, rprod_vld_q;

  assign mag    = value_i[apc_pkg::DivInW-1] ? apc_pkg::DivInW'(-value_i)
                                             : apc_pkg::DivInW'(value_i);
  assign biased = apc_pkg::DivMagW'(mag) + Bias;
  assign quo    = rprod_q[RecSh +: QuotW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_vld_q   <= 1'b0;
      rprod_vld_q <= 1'b0;
    end else begin
      red_vld_q   <= start_i;
      rprod_vld_q <= red_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      red_q <= RedW'(biased >> (Shift + 3));
      neg_q <= value_i[apc_pkg::DivInW-1];
    end
    if (red_vld_q) begin
      rprod_q <= RProdW'(red_q) * RProdW'(Recip);
    end
  end

  assign busy_o = red_vld_q;
  assign done_o = rprod_vld_q;
  assign quot_o = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

endmodule
`default_nettype wire

@@ hdl/arm_pose_checker_unit.sv @@
`default_nettype none
// Sequence: once a request is taken, the result turns valid after seven
// multiplier steps, three scalings to metres (shift and reciprocal multiply),
// five multiplier steps for the reach test and one output load.
// Flow: one request at a time; the next is taken once the result sits in
// the output register, a stalled result holds input.
// Reset (async, active low): joint angles zero, collision flag clear,
// workspace radius 32768, no result pending.
module arm_pose_checker_unit #(
  parameter int unsigned POS_FRAC_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  apc_cmd_if.sink                             cmd_i,
  apc_res_if.source                           res_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [apc_pkg::RadW-1:0]       cfg_wdata_i
);

  localparam int unsigned PW = POS_FRAC_BITS + 2;  // rounded position width
  localparam logic signed [apc_pkg::ProdW-1:0] RBase = apc_pkg::ProdW'(apc_pkg::BaseReach * 65536);
  localparam logic signed [apc_pkg::ProdW-1:0] YBase = apc_pkg::ProdW'(apc_pkg::BaseLift * 65536);
  localparam logic signed [apc_pkg::MulW-1:0]  KUpper = apc_pkg::MulW'(apc_pkg::LinkUpper);
  localparam logic signed [apc_pkg::MulW-1:0]  KFore  = apc_pkg::MulW'(apc_pkg::LinkFore);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StKin  = 5'b00010,
    StDiv  = 5'b00100,
    StSqr  = 5'b01000,
    StOut  = 5'b10000
  } state_e;

  state_e st_q, st_d;
  logic [2:0] step_q, step_d;
  logic [1:0] sel_q, sel_d;

  apc_pkg::angle_t ang_q [apc_pkg::NumJoints];
  apc_pkg::angle_t ang_d [apc_pkg::NumJoints];
  logic signed [apc_pkg::InAngW-1:0] req [apc_pkg::NumJoints];
  logic [apc_pkg::NumJoints-1:0]     req_ok;
  logic                              acc_ok;

  logic                  coll_q;
  logic [apc_pkg::RadW-1:0] radius_q;
  logic                  res_valid_q;
  logic                  cmd_take, res_load;

  // datapath holding registers
  logic                              accepted_q;
  logic signed [apc_pkg::ProdW-1:0]  acc_q;
  logic signed [apc_pkg::MulW-1:0]   r_q, yq_q;
  logic signed [apc_pkg::DivInW-1:0] xv_q, zv_q;
  logic signed [PW-1:0]              px_q, py_q, pz_q;
  logic                              coll_new_q;

  // output payload
  logic                              res_acc_q, res_coll_q, res_estop_q;
  logic signed [apc_pkg::PosW-1:0]   res_x_q, res_y_q, res_z_q;

  // shared units
  logic signed [apc_pkg::ArgW-1:0]   trig_arg;
  logic signed [apc_pkg::TrigW-1:0]  trig;
  logic signed [apc_pkg::MulW-1:0]   mul_a, mul_b;
  logic signed [apc_pkg::ProdW-1:0]  prod;
  logic                              div_start, div_busy, div_done;
  logic signed [apc_pkg::DivInW-1:0] div_val;
  logic signed [PW-1:0]              div_quot;

  logic signed [apc_pkg::ArgW-1:0]   q1, q2, q3;
  logic                              pose_coll;

  assign q1 = apc_pkg::ArgW'(ang_q[apc_pkg::JointBase]);
  assign q2 = apc_pkg::ArgW'(ang_q[apc_pkg::JointShoulder]);
  assign q3 = apc_pkg::ArgW'(ang_q[apc_pkg::JointElbow]);

  assign cmd_i.ready = (st_q == StIdle);
  assign cmd_take    = cmd_i.valid && cmd_i.ready;
  assign res_load    = (st_q == StOut) && (!res_valid_q || res_o.ready);

  // limit check and angle update of the incoming request
  always_comb begin
    req[0] = cmd_i.base_angle;
    req[1] = cmd_i.shoulder_angle;
    req[2] = cmd_i.elbow_angle;
    req[3] = cmd_i.roll_angle;
    req[4] = cmd_i.pitch_angle;
    req[5] = cmd_i.yaw_angle;
    for (int i = 0; i < apc_pkg::NumJoints; i++) begin
      req_ok[i] = apc_pkg::in_limits(apc_pkg::JointIdxW'(i), req[i]);
      ang_d[i]  = ang_q[i];
    end
    if (cmd_i.opcode == apc_pkg::OpSetAll) begin
      acc_ok = &req_ok;
      if (acc_ok) begin
        for (int i = 0; i < apc_pkg::NumJoints; i++) begin
          ang_d[i] = apc_pkg::AngW'(req[i]);
        end
      end
    end else begin
      acc_ok = apc_pkg::in_limits(cmd_i.joint_index, cmd_i.new_angle);
      for (int i = 0; i < apc_pkg::NumJoints; i++) begin
        if (acc_ok && (cmd_i.joint_index == apc_pkg::JointIdxW'(i))) begin
          ang_d[i] = apc_pkg::AngW'(cmd_i.new_angle);
        end
      end
    end
  end

  // operand selection for the shared multiplier and the sine table
  always_comb begin
    trig_arg = '0;
    case (step_q)
      3'd0:    trig_arg = q2 + apc_pkg::ArgW'(90);
      3'd1:    trig_arg = q2 + q3 + apc_pkg::ArgW'(90);
      3'd2:    trig_arg = q2;
      3'd3:    trig_arg = q2 + q3;
      3'd4:    trig_arg = q1 + apc_pkg::ArgW'(90);
      3'd5:    trig_arg = q1;
      default: trig_arg = '0;
    endcase
  end

  assign trig = apc_pkg::sine_deg(trig_arg);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (st_q == StKin) begin
      case (step_q)
        3'd0, 3'd2: begin
          mul_a = KUpper;
          mul_b = apc_pkg::MulW'(trig);
        end
        3'd1, 3'd3: begin
          mul_a = KFore;
          mul_b = apc_pkg::MulW'(trig);
        end
        3'd4, 3'd5: begin
          mul_a = apc_pkg::MulW'(trig);
          mul_b = r_q;
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end else if (st_q == StSqr) begin
      case (step_q)
        3'd0: begin
          mul_a = apc_pkg::MulW'(px_q);
          mul_b = apc_pkg::MulW'(px_q);
        end
        3'd1: begin
          mul_a = apc_pkg::MulW'(py_q);
          mul_b = apc_pkg::MulW'(py_q);
        end
        3'd2: begin
          mul_a = apc_pkg::MulW'(pz_q);
          mul_b = apc_pkg::MulW'(pz_q);
        end
        3'd3: begin
          mul_a = $signed({{(apc_pkg::MulW-apc_pkg::RadW){1'b0}}, radius_q});
          mul_b = $signed({{(apc_pkg::MulW-apc_pkg::RadW){1'b0}}, radius_q});
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  apc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // divider feed: x, then y (Q16 mm scaled to Q32), then z
  always_comb begin
    case (sel_q)
      2'd0:    div_val = xv_q;
      2'd1:    div_val = apc_pkg::DivInW'(apc_pkg::ProdW'(yq_q) <<< 16);
      2'd2:    div_val = zv_q;
      default: div_val = xv_q;
    endcase
  end

  // launch once per value; step_q[0] marks the launch as done
  assign div_start = (st_q == StDiv) && !step_q[0] && !div_busy && !div_done;

  apc_div #(
    .FracBits (POS_FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .value_i (div_val),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign pose_coll = (ang_q[apc_pkg::JointShoulder] > 60 ||
                      ang_q[apc_pkg::JointShoulder] < -60) &&
                     (ang_q[apc_pkg::JointElbow] > 100 ||
                      ang_q[apc_pkg::JointElbow] < -100);

  // sequencer
  always_comb begin
    st_d   = st_q;
    step_d = step_q;
    sel_d  = sel_q;
    case (st_q)
      StIdle: begin
        if (cmd_take) begin
          st_d   = StKin;
          step_d = '0;
        end
      end
      StKin: begin
        step_d = step_q + 3'd1;
        if (step_q == 3'd6) begin
          st_d   = StDiv;
          step_d = '0;
          sel_d  = '0;
        end
      end
      StDiv: begin
        if (div_start) begin
          step_d = 3'd1;
        end else if (div_done) begin
          step_d = '0;
          if (sel_q == 2'd2) begin
            st_d = StSqr;
          end else begin
            sel_d = sel_q + 2'd1;
          end
        end
      end
      StSqr: begin
        step_d = step_q + 3'd1;
        if (step_q == 3'd4) begin
          st_d   = StOut;
          step_d = '0;
        end
      end
      StOut: begin
        if (res_load) begin
          st_d = StIdle;
        end
      end
      default: begin
        st_d   = StIdle;
        step_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      step_q      <= '0;
      sel_q       <= '0;
      coll_q      <= 1'b0;
      radius_q    <= apc_pkg::RadW'(32768);
      res_valid_q <= 1'b0;
      for (int i = 0; i < apc_pkg::NumJoints; i++) begin
        ang_q[i] <= '0;
      end
    end else begin
      st_q   <= st_d;
      step_q <= step_d;
      sel_q  <= sel_d;
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
      if (cmd_take) begin
        ang_q <= ang_d;
      end
      // hold the flag until the result of this request is loaded into the output register
      if (res_load) begin
        coll_q      <= coll_new_q;
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  function automatic logic signed [apc_pkg::PosW-1:0] sat_pos(input logic signed [PW-1:0] v);
    logic signed [31:0] w;
    w = 32'(v);
    if (w > 32'sd32767) begin
      return 16'sh7fff;
    end else if (w < -32'sd32768) begin
      return 16'sh8000;
    end
    return apc_pkg::PosW'(w);
  endfunction

  // datapath: accumulate previous product while the next one is issued
  always_ff @(posedge clk_i) begin
    if (cmd_take) begin
      accepted_q <= acc_ok;
    end
    if (st_q == StKin) begin
      case (step_q)
        3'd1: acc_q <= RBase + prod;
        3'd2: r_q   <= apc_pkg::MulW'(acc_q + prod);
        3'd3: acc_q <= YBase + prod;
        3'd4: yq_q  <= apc_pkg::MulW'(acc_q + prod);
        3'd5: xv_q  <= apc_pkg::DivInW'(prod);
        3'd6: zv_q  <= apc_pkg::DivInW'(prod);
        default: acc_q <= acc_q;
      endcase
    end
    if ((st_q == StDiv) && div_done) begin
      case (sel_q)
        2'd0:    px_q <= div_quot;
        2'd1:    py_q <= div_quot;
        default: pz_q <= div_quot;
      endcase
    end
    if (st_q == StSqr) begin
      case (step_q)
        3'd1: acc_q <= prod;
        3'd2: acc_q <= acc_q + prod;
        3'd3: acc_q <= acc_q + prod;
        // reach sum against radius squared
        3'd4: coll_new_q <= pose_coll || (acc_q > prod);
        default: acc_q <= acc_q;
      endcase
    end
    if (res_load) begin
      res_acc_q   <= accepted_q;
      res_coll_q  <= coll_new_q;
      res_estop_q <= coll_new_q && !coll_q;
      res_x_q     <= sat_pos(px_q);
      res_y_q     <= sat_pos(py_q);
      res_z_q     <= sat_pos(pz_q);
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.accepted       = res_acc_q;
  assign res_o.pos_x          = res_x_q;
  assign res_o.pos_y          = res_y_q;
  assign res_o.pos_z          = res_z_q;
  assign res_o.collision      = res_coll_q;
  assign res_o.emergency_stop = res_estop_q;

  a_estop_needs_coll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (!res_o.emergency_stop || res_o.collision))
    else $error("emergency stop without collision");

  a_angles_hold_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |=> ($stable(ang_q[0]) && $stable(ang_q[1]) && $stable(ang_q[2])))
    else $error("joint angles changed during computation");

  a_shoulder_in_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ang_q[apc_pkg::JointShoulder] <= 90) && (ang_q[apc_pkg::JointShoulder] >= -90))
    else $error("shoulder angle out of limits");

  a_load_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(st_q == StOut))
    else $error("result loaded outside output step");

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`default_nettype none
module testbench;

  // One joint request as the sender sees it.
  typedef struct packed {
    logic             opcode;
    logic [2:0]       joint_index;
    logic signed [9:0] new_angle;
    logic signed [9:0] base_angle;
    logic signed [9:0] shoulder_angle;
    logic signed [9:0] elbow_angle;
    logic signed [9:0] roll_angle;
    logic signed [9:0] pitch_angle;
    logic signed [9:0] yaw_angle;
  } pose_req_t;

  // Expected pose report for one request.
  typedef struct packed {
    logic              accepted;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic              collision;
    logic              emergency_stop;
  } pose_rpt_t;

  localparam int FracBits = 16;
  localparam int PostFlushCycles = 150;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [apc_pkg::RadW-1:0] cfg_wdata_i;

  apc_cmd_if cmd ();
  apc_res_if res ();

  arm_pose_checker_unit #(.POS_FRAC_BITS(FracBits)) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd.sink),
    .res_o      (res.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Predictor state: our own copy of the arm.
  int        arm_deg [6];
  bit        arm_collided;
  int        reach_radius;
  int        sine_q16 [91];
  int        joint_lim [6];

  pose_req_t pending_reqs [$];
  pose_rpt_t expected_rpts [$];

  int        mismatch_cnt;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_off_cycles;
  bit        req_taken;

  function automatic int sin_deg(int d);
    int a;
    a = d % 360;
    if (a < 0) a += 360;
    if (a <= 90) return sine_q16[a];
    if (a <= 180) return sine_q16[180 - a];
    if (a <= 270) return -sine_q16[a - 180];
    return -sine_q16[360 - a];
  endfunction

  // Q32 mm to metres at FracBits, rounding half away from zero at both steps.
  function automatic longint mm_to_pos(longint v);
    longint mag;
    longint q;
    longint p;
    mag = (v < 0) ? -v : v;
    q = (mag + 500) / 1000;
    p = (q + (64'sd1 << (32 - FracBits - 1))) >>> (32 - FracBits);
    return (v < 0) ? -p : p;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic pose_rpt_t predict_pose(pose_req_t r);
    pose_rpt_t o;
    int        req [6];
    bit        ok;
    int        q1, q2, q3;
    longint    rr, yq, px, py, pz;
    longint unsigned reach, lim;
    bit        coll;
    ok = 1'b0;
    if (r.opcode == apc_pkg::OpSetOne) begin
      if (r.joint_index < 6 && r.new_angle >= -joint_lim[r.joint_index] &&
          r.new_angle <= joint_lim[r.joint_index]) begin
        arm_deg[r.joint_index] = r.new_angle;
        ok = 1'b1;
      end
    end else begin
      req = '{r.base_angle, r.shoulder_angle, r.elbow_angle, r.roll_angle,
              r.pitch_angle, r.yaw_angle};
      ok = 1'b1;
      for (int i = 0; i < 6; i++)
        if (req[i] < -joint_lim[i] || req[i] > joint_lim[i]) ok = 1'b0;
      if (ok) arm_deg = req;
    end
    q1 = arm_deg[0];
    q2 = arm_deg[1];
    q3 = arm_deg[2];
    rr = 64'sd173 * 65536 + 64'sd89 * sin_deg(q2 + 90) + 64'sd169 * sin_deg(q2 + q3 + 90);
    yq = 64'sd196 * 65536 + 64'sd89 * sin_deg(q2) + 64'sd169 * sin_deg(q2 + q3);
    px = mm_to_pos(longint'(sin_deg(q1 + 90)) * rr);
    py = mm_to_pos(yq * 65536);
    pz = mm_to_pos(longint'(sin_deg(q1)) * rr);
    reach = px * px + py * py + pz * pz;
    lim = longint'(reach_radius) * reach_radius;
    coll = ((q2 > 60 || q2 < -60) && (q3 > 100 || q3 < -100)) || reach > lim;
    o.accepted = ok;
    o.pos_x = clamp16(px);
    o.pos_y = clamp16(py);
    o.pos_z = clamp16(pz);
    o.collision = coll;
    o.emergency_stop = coll && !arm_collided;
    arm_collided = coll;
    return o;
  endfunction

  function automatic logic signed [9:0] rand_angle(int lim);
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 10'($urandom);
    if (k == 1) return 10'(($urandom & 1) ? lim : -lim);
    if (k == 2) return 10'(($urandom & 1) ? lim + 1 : -lim - 1);
    return 10'($signed($urandom_range(0, 2 * lim)) - lim);
  endfunction

  function automatic pose_req_t rand_req();
    pose_req_t r;
    r = pose_req_t'(74'({$urandom, $urandom, $urandom}));
    if ($urandom_range(0, 1)) begin
      r.opcode = apc_pkg::OpSetOne;
      r.joint_index = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                   : 3'($urandom_range(0, 5));
      if (r.joint_index < 6) r.new_angle = rand_angle(joint_lim[r.joint_index]);
    end else begin
      r.opcode = apc_pkg::OpSetAll;
      r.base_angle = rand_angle(180);
      r.shoulder_angle = rand_angle(90);
      r.elbow_angle = rand_angle(135);
      r.roll_angle = rand_angle(180);
      r.pitch_angle = rand_angle(90);
      r.yaw_angle = rand_angle(180);
    end
    return r;
  endfunction

  function automatic pose_req_t one_joint(int j, int a);
    pose_req_t r;
    r = '0;
    r.opcode = apc_pkg::OpSetOne;
    r.joint_index = 3'(j);
    r.new_angle = 10'(a);
    return r;
  endfunction

  function automatic pose_req_t all_joints(int b, int s, int e, int ro, int p, int y);
    pose_req_t r;
    r = pose_req_t'(74'({$urandom, $urandom, $urandom}));
    r.opcode = apc_pkg::OpSetAll;
    r.base_angle = 10'(b);
    r.shoulder_angle = 10'(s);
    r.elbow_angle = 10'(e);
    r.roll_angle = 10'(ro);
    r.pitch_angle = 10'(p);
    r.yaw_angle = 10'(y);
    return r;
  endfunction

  // Driver: offer the head of the request queue, change on the falling edge.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      cmd.valid <= 1'b0;
    end else if (cmd.valid && !req_taken) begin
      // hold the request until it is taken
    end else if (pending_reqs.size() != 0 &&
                 $urandom_range(0, 99) >= send_idle_pct) begin
      cmd.valid          <= 1'b1;
      cmd.opcode         <= pending_reqs[0].opcode;
      cmd.joint_index    <= pending_reqs[0].joint_index;
      cmd.new_angle      <= pending_reqs[0].new_angle;
      cmd.base_angle     <= pending_reqs[0].base_angle;
      cmd.shoulder_angle <= pending_reqs[0].shoulder_angle;
      cmd.elbow_angle    <= pending_reqs[0].elbow_angle;
      cmd.roll_angle     <= pending_reqs[0].roll_angle;
      cmd.pitch_angle    <= pending_reqs[0].pitch_angle;
      cmd.yaw_angle      <= pending_reqs[0].yaw_angle;
      pending_reqs.pop_front();
    end else begin
      cmd.valid <= 1'b0;
    end
  end

  // Receiver backpressure; a long hold-off is counted down here.
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on request acceptance, check on result acceptance.
  always @(posedge clk_i) begin
    pose_rpt_t exp_r;
    pose_req_t taken;
    req_taken <= rst_ni && cmd.valid && cmd.ready;
    if (rst_ni && cmd.valid && cmd.ready) begin
      taken = '{cmd.opcode, cmd.joint_index, cmd.new_angle, cmd.base_angle,
                cmd.shoulder_angle, cmd.elbow_angle, cmd.roll_angle,
                cmd.pitch_angle, cmd.yaw_angle};
      expected_rpts.push_back(predict_pose(taken));
    end
    if (rst_ni && res.valid && res.ready) begin
      if (expected_rpts.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        exp_r = expected_rpts.pop_front();
        if (exp_r.accepted !== res.accepted || exp_r.pos_x !== res.pos_x ||
            exp_r.pos_y !== res.pos_y || exp_r.pos_z !== res.pos_z ||
            exp_r.collision !== res.collision ||
            exp_r.emergency_stop !== res.emergency_stop) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch at %0t: exp acc=%0d x=%0d y=%0d z=%0d coll=%0d estop=%0d",
                     $realtime, exp_r.accepted, exp_r.pos_x, exp_r.pos_y, exp_r.pos_z,
                     exp_r.collision, exp_r.emergency_stop,
                     " got acc=%0d x=%0d y=%0d z=%0d coll=%0d estop=%0d",
                     res.accepted, res.pos_x, res.pos_y, res.pos_z, res.collision,
                     res.emergency_stop);
        end
      end
    end
  end

  // Wait until every request has been taken and answered, then let the block settle.
  task automatic drain();
    while (pending_reqs.size() != 0 || cmd.valid || expected_rpts.size() != 0)
      @(posedge clk_i);
    repeat (PostFlushCycles) @(posedge clk_i);
  endtask

  task automatic set_radius(int value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= apc_pkg::RadW'(value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    reach_radius = value;
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) pending_reqs.push_back(rand_req());
  endtask

  initial begin
    sine_q16 = '{0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
      11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
      22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
      32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
      42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
      50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
      56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
      61584, 61965, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
      64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
      65536};
    joint_lim = '{180, 90, 135, 180, 90, 180};
    arm_deg = '{0, 0, 0, 0, 0, 0};
    arm_collided = 1'b0;
    reach_radius = 32768;
    mismatch_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    cmd.valid = 1'b0;
    cmd.opcode = apc_pkg::OpSetOne;
    cmd.joint_index = '0;
    cmd.new_angle = '0;
    cmd.base_angle = '0;
    cmd.shoulder_angle = '0;
    cmd.elbow_angle = '0;
    cmd.roll_angle = '0;
    cmd.pitch_angle = '0;
    cmd.yaw_angle = '0;
    res.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: limit edges per joint, bad indexes, set-all pass/fail,
    // the shoulder/elbow collision corner, unused fields ignored.
    for (int j = 0; j < 6; j++) begin
      pending_reqs.push_back(one_joint(j, joint_lim[j]));
      pending_reqs.push_back(one_joint(j, -joint_lim[j] - 1));
    end
    pending_reqs.push_back(one_joint(6, 0));
    pending_reqs.push_back(one_joint(7, -512));
    pending_reqs.push_back(one_joint(0, 511));
    pending_reqs.push_back(all_joints(-180, -90, -135, -180, -90, -180));
    pending_reqs.push_back(all_joints(180, 61, 101, 180, 90, 180));
    pending_reqs.push_back(all_joints(0, 60, 100, 0, 0, 0));
    pending_reqs.push_back(all_joints(-512, 0, 0, 0, 0, 0));
    pending_reqs.push_back(all_joints(0, 0, 0, 0, 0, 511));
    pending_reqs.push_back(all_joints(90, -61, -101, 5, 5, 5));
    pending_reqs.push_back(all_joints(0, 0, 0, 0, 0, 0));
    drain();

    // Extreme radii: everything collides, then nothing from reach.
    set_radius(0);
    pending_reqs.push_back(all_joints(45, 30, 30, 0, 0, 0));
    pending_reqs.push_back(one_joint(6, 1));
    drain();
    set_radius(65535);
    pending_reqs.push_back(one_joint(7, 1));
    drain();

    // Random phases across idling profiles and radii.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      set_radius((ph == 3) ? 65535 : (ph == 6) ? 0 : $urandom_range(10000, 40000));
      if (ph == 2) hold_off_cycles = 600;
      queue_random(160);
      drain();
    end
    if (mismatch_cnt == 0 && expected_rpts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire

@@ arm_pose_checker_unit.f @@
hdl/apc_pkg.sv
hdl/apc_if.sv
hdl/apc_mul.sv
hdl/apc_div.sv
hdl/arm_pose_checker_unit.sv
bench/testbench.sv
